// ----- rtl/charge_transfer_moisture_sensor_assert.svh -----
// Assertion macros for the charge-transfer moisture sensor.
`ifndef CHARGE_TRANSFER_MOISTURE_SENSOR_ASSERT_SVH
`define CHARGE_TRANSFER_MOISTURE_SENSOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CTMS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ctms assertion failed");

// Next-cycle implication, disabled during reset.
`define CTMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ctms assertion failed");

`endif

// ----- rtl/ctms_pkg.sv -----
// Shared types, codes and calibration table for the moisture sensor.
package ctms_pkg;

    localparam int CAL_POINTS = 9;
    localparam int CNT_W      = 10;
    localparam int PCT_W      = 7;
    localparam int NUM_W      = PCT_W + CNT_W;
    localparam int Q_W        = 4;
    localparam int DSH_W      = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CNT_W-1:0] CAL_CNT [CAL_POINTS] =
        '{10'd1000, 10'd500, 10'd350, 10'd200, 10'd160, 10'd120, 10'd110, 10'd95, 10'd85};
    localparam logic [PCT_W-1:0] CAL_PCT [CAL_POINTS] =
        '{7'd0, 7'd12, 7'd25, 7'd37, 7'd50, 7'd63, 7'd75, 7'd88, 7'd100};

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_DISCHARGE = 2'd1;
    localparam logic [1:0] PH_CHARGE    = 2'd2;
    localparam logic [1:0] PH_TRANSFER  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_LIMIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_TICKS = 1'd1;

    localparam logic [15:0] CYCLE_LIMIT_RST     = 16'd1000;
    localparam logic [15:0] DISCHARGE_TICKS_RST = 16'd10;

    typedef struct packed {
        logic             step;
        logic             seg;
        logic             div;
        logic [DSH_W-1:0] div_sh;
        logic             wb;
    } t_cmd;

    typedef struct packed {
        logic need_pct;
    } t_sts;

endpackage

// ----- rtl/ctms_ctrl.sv -----
// Handshake and percent-calculation controller.
module ctms_ctrl
    import ctms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_SEG = 2'd1;
    localparam logic [1:0] ST_DIV = 2'd2;
    localparam logic [1:0] ST_WB  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [DSH_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept;

    assign o_in_ready  = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.step   = accept;
        o_cmd.div_sh = r_cnt;
        unique case (r_state)
            ST_RUN: begin
                if (accept && i_sts.need_pct) n_state = ST_SEG;
            end
            ST_SEG: begin
                o_cmd.seg = 1'b1;
                n_cnt     = {DSH_W{1'b1}};
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (r_cnt == '0) n_state = ST_WB;
                else n_cnt = r_cnt - 1'b1;
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = ST_RUN;
            end
            default: n_state = ST_RUN;
        endcase

        priority if ((accept && !i_sts.need_pct) || o_cmd.wb) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/ctms_dp.sv -----
// Sensor sequencer state, configuration and percent interpolation unit.
module ctms_dp
    import ctms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_start_req,
    input  logic                 i_relative_mode,
    input  logic                 i_pin0_level,
    input  logic                 i_pin2_level,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_pin0_drive_enable,
    output logic                 o_pin0_drive_value,
    output logic                 o_pin2_drive_enable,
    output logic                 o_pin2_drive_value,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [15:0]          o_reading
);

    logic [15:0]      r_limit, r_dticks;
    logic [1:0]       r_phase, n_phase;
    logic [15:0]      r_count, n_count;
    logic [15:0]      r_timer, n_timer;
    logic             r_rp, n_rp;
    logic [15:0]      r_last, n_last;
    logic             r_done, n_done;

    // percent unit
    logic [15:0]      r_pv;
    logic [NUM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_den;
    logic [PCT_W-1:0] r_base;
    logic [Q_W-1:0]   r_q;

    logic [15:0]      c_inc, t_dec;
    logic             fin;
    logic [NUM_W-1:0] s_num;
    logic [CNT_W-1:0] s_den;
    logic [PCT_W-1:0] s_base;
    logic [NUM_W-1:0] d_shift;
    logic [PCT_W-1:0] wb_val;

    assign c_inc = (r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;
    assign t_dec = (r_timer != 16'd0) ? r_timer - 16'd1 : r_timer;
    assign fin   = (c_inc >= r_limit) || i_pin2_level;

    assign o_sts.need_pct = (r_phase == PH_TRANSFER) && fin && r_rp;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_timer = r_timer;
        n_rp    = r_rp;
        n_last  = r_last;
        n_done  = r_done;
        wb_val  = r_base + PCT_W'(r_q);
        if (i_cmd.step) begin
            n_done = 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start_req) begin
                        n_rp    = i_relative_mode;
                        n_count = 16'd0;
                        n_timer = (r_dticks != 16'd0) ? r_dticks : 16'd1;
                        n_phase = PH_DISCHARGE;
                    end
                end
                PH_DISCHARGE: begin
                    n_timer = t_dec;
                    if (t_dec == 16'd0) n_phase = PH_CHARGE;
                end
                PH_CHARGE: begin
                    if (i_pin0_level) n_phase = PH_TRANSFER;
                end
                PH_TRANSFER: begin
                    n_count = c_inc;
                    if (fin) begin
                        if (!r_rp) n_last = c_inc;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = PH_CHARGE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
        if (i_cmd.wb) n_last = 16'(wb_val);
    end

    // Segment lookup; outside the table the result clamps via a zero numerator.
    always_comb begin
        s_num  = '0;
        s_den  = CNT_W'(1);
        s_base = CAL_PCT[CAL_POINTS-1];
        if (r_pv >= 16'(CAL_CNT[0])) begin
            s_base = CAL_PCT[0];
        end else if (r_pv > 16'(CAL_CNT[CAL_POINTS-1])) begin
            for (int k = 0; k < CAL_POINTS - 1; k++) begin
                if (r_pv <= 16'(CAL_CNT[k]) && r_pv > 16'(CAL_CNT[k+1])) begin
                    s_base = CAL_PCT[k];
                    s_den  = CAL_CNT[k] - CAL_CNT[k+1];
                    s_num  = NUM_W'(CAL_PCT[k+1] - CAL_PCT[k])
                           * NUM_W'(CAL_CNT[k] - r_pv[CNT_W-1:0]);
                end
            end
        end
    end

    assign d_shift = NUM_W'(r_den) << i_cmd.div_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CYCLE_LIMIT_RST;
            r_dticks <= DISCHARGE_TICKS_RST;
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_timer <= '0;
            r_rp    <= 1'b0;
            r_last  <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CYCLE_LIMIT:     r_limit  <= i_cfg_data;
                    CFG_DISCHARGE_TICKS: r_dticks <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_count <= n_count;
            r_timer <= n_timer;
            r_rp    <= n_rp;
            r_last  <= n_last;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) r_pv <= c_inc;
        if (i_cmd.seg) begin
            r_rem  <= s_num;
            r_den  <= s_den;
            r_base <= s_base;
            r_q    <= '0;
        end
        if (i_cmd.div && r_rem >= d_shift) begin
            r_rem              <= r_rem - d_shift;
            r_q[i_cmd.div_sh]  <= 1'b1;
        end
    end

    assign o_pin0_drive_enable = (r_phase == PH_DISCHARGE) || (r_phase == PH_TRANSFER);
    assign o_pin0_drive_value  = 1'b0;
    assign o_pin2_drive_enable = (r_phase == PH_DISCHARGE) || (r_phase == PH_CHARGE);
    assign o_pin2_drive_value  = (r_phase == PH_CHARGE);
    assign o_busy_res          = (r_phase != PH_IDLE);
    assign o_done_res          = r_done;
    assign o_reading           = r_last;

endmodule

// ----- rtl/charge_transfer_moisture_sensor.sv -----
// Charge-transfer moisture sensor: top level.
// Result: registered from the accepted request; a request that completes
//   a percentage reading first runs segment lookup, a 4-step divider and write-back.
// Throughput: one request per cycle; a percentage reading holds the input off
//   during its lookup, divide and write-back states; a stalled result, until taken.
// Reset: synchronous, active low; phase idle, reading 0, registers to defaults.
module charge_transfer_moisture_sensor
    import ctms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_start_req,
    input  logic                 i_relative_mode,
    input  logic                 i_pin0_level,
    input  logic                 i_pin2_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_pin0_drive_enable,
    output logic                 o_pin0_drive_value,
    output logic                 o_pin2_drive_enable,
    output logic                 o_pin2_drive_value,
    output logic                 o_busy_res,
    output logic                 o_done_res,
    output logic [15:0]          o_reading
);

    t_cmd cmd;
    t_sts sts;

    ctms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ctms_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_start_req         (i_start_req),
        .i_relative_mode     (i_relative_mode),
        .i_pin0_level        (i_pin0_level),
        .i_pin2_level        (i_pin2_level),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_pin0_drive_enable (o_pin0_drive_enable),
        .o_pin0_drive_value  (o_pin0_drive_value),
        .o_pin2_drive_enable (o_pin2_drive_enable),
        .o_pin2_drive_value  (o_pin2_drive_value),
        .o_busy_res          (o_busy_res),
        .o_done_res          (o_done_res),
        .o_reading           (o_reading)
    );

endmodule

// ----- rtl/ctms_chk.sv -----
// Port-level checker for the moisture sensor, bound to the top level.
`include "charge_transfer_moisture_sensor_assert.svh"

module ctms_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_busy_res,
    input logic o_done_res,
    input logic o_pin0_drive_value,
    input logic o_pin2_drive_enable,
    input logic o_pin2_drive_value
);

    // a completed reading always returns to idle
    `CTMS_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)
    // pin0 is only ever pulled low (checked while a result is offered)
    `CTMS_ASSERT_NOW(a_pin0_low, i_clk, i_rst_n, o_out_valid, !o_pin0_drive_value)
    // pin2 high drive only while enabled and busy (checked while a result is offered)
    `CTMS_ASSERT_NOW(a_pin2_drv, i_clk, i_rst_n, o_out_valid && o_pin2_drive_value,
        o_pin2_drive_enable && o_busy_res)
    // stalled result stays offered
    `CTMS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

endmodule

bind charge_transfer_moisture_sensor ctms_chk u_ctms_chk (.*);
